// File: rtl/command_framer_ack_matcher_unit_assert.svh
// ----------------------------------------------------------------------------
// Command framer assertion macros
// Shared property macros for the command framer and acknowledge matcher.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAMER_ACK_MATCHER_UNIT_ASSERT_SVH
`define COMMAND_FRAMER_ACK_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define CFAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfam: same-cycle check failed");

// next-cycle implication, held off during reset
`define CFAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfam: next-cycle check failed");

`endif

// File: rtl/cfam_pkg.sv
// ----------------------------------------------------------------------------
// cfam_pkg
// Types and constants shared by the command framer and acknowledge matcher.
// ----------------------------------------------------------------------------
package cfam_pkg;

  localparam int MAX_BODY = 16;
  localparam int CNT_W    = $clog2(MAX_BODY + 1);
  localparam int IDX_W    = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam int POS_W    = $clog2(MAX_BODY + 9);
  localparam int TICK_W   = 15;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  localparam logic [7:0] HDR0_BYTE = 8'hA0;
  localparam logic [7:0] HDR1_BYTE = 8'hA1;
  localparam logic [7:0] TRL0_BYTE = 8'h0D;
  localparam logic [7:0] TRL1_BYTE = 8'h0A;
  localparam logic [7:0] ACK_BYTE  = 8'h83;
  localparam logic [7:0] NACK_BYTE = 8'h84;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    MODE_BODY = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_ACK     = 2'd0,
    ST_NACK    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_WAIT    = 2'd2
  } phase_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_FRAME = 1'b1
  } back_state_t;

  // request passed from the classifier to the emitter
  typedef struct packed {
    logic             is_frame;
    status_t          status;
    logic [CNT_W-1:0] count;
    logic [7:0]       id;
  } cmd_t;

  typedef struct packed {
    logic room;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

endpackage

// File: rtl/cfam_in_if.sv
// ----------------------------------------------------------------------------
// cfam_in_if
// Input channel: body bytes, received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
interface cfam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  message_id;
  logic [7:0]  data_byte;
  logic        body_end;
  logic [15:0] timeout_ms;

  modport source (output valid, output mode, output message_id, output data_byte,
                  output body_end, output timeout_ms, input ready);
  modport sink   (input valid, input mode, input message_id, input data_byte,
                  input body_end, input timeout_ms, output ready);
endinterface

// File: rtl/cfam_out_if.sv
// ----------------------------------------------------------------------------
// cfam_out_if
// Result channel: transmit bytes and final command status.
// ----------------------------------------------------------------------------
interface cfam_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic [1:0] status;
  logic       end_of_run;

  modport source (output valid, output kind, output tx_byte, output status,
                  output end_of_run, input ready);
  modport sink   (input valid, input kind, input tx_byte, input status,
                  input end_of_run, output ready);
endinterface

// File: rtl/cfam_ram.sv
// ----------------------------------------------------------------------------
// cfam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/cfam_queue.sv
// ----------------------------------------------------------------------------
// cfam_queue
// Short request queue between the classifier and the frame emitter.
// ----------------------------------------------------------------------------
module cfam_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfam_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output cfam_pkg::cmd_t   head_cmd,
  output cfam_pkg::q_stat_t q_stat
);
  import cfam_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd     = mem_r[rd_ptr_r];
  assign q_stat.room  = (fill_r != QCNT_W'(QDEPTH));
  assign q_stat.empty = (fill_r == '0);

endmodule

// File: rtl/cfam_front.sv
// ----------------------------------------------------------------------------
// cfam_front
// Accepts input items, collects the body, tracks the reply header and the
// tick window, and queues frame or status requests for the emitter.
// ----------------------------------------------------------------------------
`include "command_framer_ack_matcher_unit_assert.svh"

module cfam_front (
  input  logic              clk,
  input  logic              rst_n,
  cfam_in_if.sink           in_ch,
  input  cfam_pkg::q_stat_t q_stat,
  input  logic              back_busy,
  output logic              push,
  output cfam_pkg::cmd_t    push_cmd,
  output cfam_pkg::ram_wr_t ram_wr
);
  import cfam_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [TICK_W-1:0] window_r, window_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic              retry_r, retry_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic              hdr_r, hdr_nxt;

  logic              acc;
  logic              back_quiet;
  mode_t             mode_c;
  logic              hdr_c;
  logic [TICK_W-1:0] el_inc;
  logic              fin;
  status_t           fin_st;
  logic              retry_c;
  logic              final_c;
  logic              body_take;
  logic              body_last;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W-1:0]  cnt_new;
  logic [7:0]        id_cur;

  // body writes wait until the emitter no longer reads the store
  assign back_quiet  = q_stat.empty && !back_busy;
  assign mode_c      = mode_t'(in_ch.mode);
  assign in_ch.ready = q_stat.room && ((mode_c != MODE_BODY) || back_quiet);
  assign acc         = in_ch.valid && in_ch.ready;

  // classify the item
  always_comb begin
    hdr_c     = hdr_r || (prev_r == HDR0_BYTE && in_ch.data_byte == HDR1_BYTE);
    el_inc    = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;
    fin       = 1'b0;
    fin_st    = ST_ACK;
    body_take = 1'b0;
    body_last = 1'b0;
    if (acc) begin
      case (mode_c)
        MODE_BODY: begin
          if (phase_r != PH_WAIT) begin
            body_take = 1'b1;
            body_last = in_ch.body_end;
          end
        end
        MODE_RX: begin
          if (phase_r == PH_WAIT && hdr_c &&
              (prev_r == ACK_BYTE || prev_r == NACK_BYTE)) begin
            fin = 1'b1;
            if (in_ch.data_byte != id_r) begin
              fin_st = ST_UNKNOWN;
            end else if (prev_r == ACK_BYTE) begin
              fin_st = ST_ACK;
            end else begin
              fin_st = ST_NACK;
            end
          end
        end
        MODE_TICK: begin
          if (phase_r == PH_WAIT && el_inc >= window_r) begin
            fin    = 1'b1;
            fin_st = ST_TIMEOUT;
          end
        end
        default: ;
      endcase
    end
    retry_c  = fin && (fin_st != ST_ACK) && !retry_r;
    final_c  = fin && !retry_c;
    cnt_base = (phase_r == PH_IDLE) ? '0 : count_r;
    id_cur   = (phase_r == PH_IDLE) ? in_ch.message_id : id_r;
    cnt_new  = (cnt_base < CNT_W'(MAX_BODY)) ? cnt_base + 1'b1 : cnt_base;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (body_take) begin
      phase_nxt = body_last ? PH_WAIT : PH_COLLECT;
    end
    if (retry_c) begin
      phase_nxt = PH_WAIT;
    end
    if (final_c) begin
      phase_nxt = PH_IDLE;
    end
  end

  // datapath and request outputs
  always_comb begin
    count_nxt   = count_r;
    id_nxt      = id_r;
    window_nxt  = window_r;
    elapsed_nxt = elapsed_r;
    retry_nxt   = retry_r;
    prev_nxt    = prev_r;
    hdr_nxt     = hdr_r;
    push        = 1'b0;
    push_cmd    = '{is_frame: 1'b0, status: ST_ACK, count: count_r, id: id_r};
    ram_wr      = '{we: 1'b0, addr: cnt_base[IDX_W-1:0], data: in_ch.data_byte};

    if (body_take) begin
      id_nxt    = id_cur;
      count_nxt = cnt_new;
      if (phase_r == PH_IDLE) begin
        window_nxt = in_ch.timeout_ms[15:1];
        retry_nxt  = 1'b0;
      end
      // drop bytes past the store
      ram_wr.we = (cnt_base < CNT_W'(MAX_BODY));
      if (body_last) begin
        push        = 1'b1;
        push_cmd    = '{is_frame: 1'b1, status: ST_ACK, count: cnt_new, id: id_cur};
        elapsed_nxt = '0;
        hdr_nxt     = 1'b0;
        prev_nxt    = '0;
      end
    end

    if (acc && phase_r == PH_WAIT && !fin) begin
      if (mode_c == MODE_RX) begin
        prev_nxt = in_ch.data_byte;
        hdr_nxt  = hdr_c;
      end else if (mode_c == MODE_TICK) begin
        elapsed_nxt = el_inc;
      end
    end

    if (retry_c) begin
      retry_nxt   = 1'b1;
      push        = 1'b1;
      push_cmd    = '{is_frame: 1'b1, status: ST_ACK, count: count_r, id: id_r};
      elapsed_nxt = '0;
      hdr_nxt     = 1'b0;
      prev_nxt    = '0;
    end

    if (final_c) begin
      push        = 1'b1;
      push_cmd    = '{is_frame: 1'b0, status: fin_st, count: count_r, id: id_r};
      count_nxt   = '0;
      retry_nxt   = 1'b0;
      elapsed_nxt = '0;
      hdr_nxt     = 1'b0;
      prev_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= '0;
      id_r      <= '0;
      window_r  <= '0;
      elapsed_r <= '0;
      retry_r   <= 1'b0;
      prev_r    <= '0;
      hdr_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      id_r      <= id_nxt;
      window_r  <= window_nxt;
      elapsed_r <= elapsed_nxt;
      retry_r   <= retry_nxt;
      prev_r    <= prev_nxt;
      hdr_r     <= hdr_nxt;
    end
  end

  `CFAM_ASSERT_IMPL(a_push_room, clk, rst_n, push, q_stat.room)
  `CFAM_ASSERT_IMPL(a_wr_quiet, clk, rst_n, ram_wr.we, back_quiet)
  `CFAM_ASSERT_NEXT(a_frame_wait, clk, rst_n, rst_n && push && push_cmd.is_frame, phase_r == PH_WAIT)

endmodule

// File: rtl/cfam_back.sv
// ----------------------------------------------------------------------------
// cfam_back
// Takes queued requests and drives the result channel: a whole frame one
// byte per cycle while the channel is ready, or a single status result.
// ----------------------------------------------------------------------------
`include "command_framer_ack_matcher_unit_assert.svh"

module cfam_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfam_pkg::cmd_t              head_cmd,
  input  cfam_pkg::q_stat_t           q_stat,
  output logic                        pop,
  output logic [cfam_pkg::IDX_W-1:0]  rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        back_busy,
  cfam_out_if.source                  out_ch
);
  import cfam_pkg::*;

  localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LENHI = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LENLO = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ID    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_BODY  = POS_W'(5);

  back_state_t      state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_eor_r, out_eor_nxt;

  logic             load;
  logic [POS_W-1:0] sum_pos;
  logic [POS_W-1:0] last_pos;
  logic [15:0]      len;
  logic             in_body;
  logic [7:0]       frame_byte;
  logic [POS_W-1:0] rd_pos;

  assign load     = !out_valid_r || out_ch.ready;
  assign sum_pos  = POS_W'(cnt_r) + POS_BODY;
  assign last_pos = sum_pos + POS_W'(2);
  assign len      = 16'(cnt_r) + 16'd1;
  assign in_body  = (pos_r >= POS_BODY) && (pos_r < sum_pos);

  always_comb begin
    if (pos_r == '0) begin
      frame_byte = HDR0_BYTE;
    end else if (pos_r == POS_HDR1) begin
      frame_byte = HDR1_BYTE;
    end else if (pos_r == POS_LENHI) begin
      frame_byte = len[15:8];
    end else if (pos_r == POS_LENLO) begin
      frame_byte = len[7:0];
    end else if (pos_r == POS_ID) begin
      frame_byte = id_r;
    end else if (in_body) begin
      frame_byte = rd_data;
    end else if (pos_r == sum_pos) begin
      frame_byte = sum_r;
    end else if (pos_r == sum_pos + 1'b1) begin
      frame_byte = TRL0_BYTE;
    end else begin
      frame_byte = TRL1_BYTE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && load && head_cmd.is_frame) begin
          state_nxt = BK_FRAME;
        end
      end
      BK_FRAME: begin
        if (load && pos_r == last_pos) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop            = 1'b0;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    id_nxt         = id_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_eor_nxt    = out_eor_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && load) begin
          pop = 1'b1;
          if (head_cmd.is_frame) begin
            pos_nxt = '0;
            cnt_nxt = head_cmd.count;
            id_nxt  = head_cmd.id;
            sum_nxt = head_cmd.id;
          end else begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_STATUS;
            out_byte_nxt   = '0;
            out_status_nxt = head_cmd.status;
            out_eor_nxt    = 1'b1;
          end
        end
      end
      BK_FRAME: begin
        if (load) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_TX;
          out_byte_nxt   = frame_byte;
          out_status_nxt = ST_ACK;
          out_eor_nxt    = (pos_r == last_pos);
          pos_nxt        = pos_r + 1'b1;
          if (in_body) begin
            sum_nxt = sum_r ^ rd_data;
          end
        end
      end
      default: ;
    endcase
  end

  // fetch the body byte for the position held next cycle
  assign rd_pos  = pos_nxt - POS_BODY;
  assign rd_addr = rd_pos[IDX_W-1:0];

  assign back_busy = (state_r != BK_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    id_r         <= id_nxt;
    sum_r        <= sum_nxt;
    out_kind_r   <= out_kind_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_eor_r    <= out_eor_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.tx_byte    = out_byte_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.end_of_run = out_eor_r;

  `CFAM_ASSERT_IMPL(a_pos_range, clk, rst_n, state_r == BK_FRAME, pos_r <= last_pos)
  `CFAM_ASSERT_IMPL(a_status_eor, clk, rst_n, out_valid_r && out_kind_r == KIND_STATUS, out_eor_r)
  `CFAM_ASSERT_IMPL(a_pop_full, clk, rst_n, pop, !q_stat.empty)

endmodule

// File: rtl/command_framer_ack_matcher_unit.sv
// ----------------------------------------------------------------------------
// command_framer_ack_matcher_unit
// Binary command framer with XOR checksum and ack/nack reply matching.
// ----------------------------------------------------------------------------
// Received bytes, ticks and body bytes that end no command are taken one per
// cycle while the request queue has room. A command's last body byte, and the
// first failed attempt, queue a frame of body count + 8 bytes that leaves at
// one byte per cycle through the output register while the receiver is ready,
// once the emitter picks it up; a final status is one result. The body store
// has one write and one read port, so a body byte is held off while any
// request is still queued or a frame is being sent. Each input item causes at
// most one frame or one status, and its last result carries end_of_run.
// ----------------------------------------------------------------------------
module command_framer_ack_matcher_unit (
  input  logic       clk,
  input  logic       rst_n,
  cfam_in_if.sink    in_ch,
  cfam_out_if.source out_ch
);
  import cfam_pkg::*;

  logic             push;
  cmd_t             push_cmd;
  logic             pop;
  cmd_t             head_cmd;
  q_stat_t          q_stat;
  ram_wr_t          ram_wr;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             back_busy;

  cfam_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .back_busy(back_busy),
    .push     (push),
    .push_cmd (push_cmd),
    .ram_wr   (ram_wr)
  );

  cfam_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .q_stat  (q_stat)
  );

  cfam_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BODY)
  ) u_body_ram (
    .clk  (clk),
    .we   (ram_wr.we),
    .waddr(ram_wr.addr),
    .wdata(ram_wr.data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  cfam_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_stat   (q_stat),
    .pop      (pop),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .back_busy(back_busy),
    .out_ch   (out_ch)
  );

endmodule

// File: dv/cfam_frame_monitor.sv
// ----------------------------------------------------------------------------
// cfam_frame_monitor
// Watches both channels of the command framer, predicts the frame bytes and
// final statuses from every accepted request, and compares them in order.
// ----------------------------------------------------------------------------
module cfam_frame_monitor (
  input  logic             clk,
  input  logic             rst_n,
  cfam_in_if               in_mon,
  cfam_out_if              out_mon,
  output int               mismatch_count,
  output int               pending_results,
  output cfam_pkg::phase_t cmd_phase
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfam_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    status_t    status;
    logic       end_of_run;
  } result_t;

  // predicted block state
  logic [7:0]        body_mem [MAX_BODY];
  logic [CNT_W-1:0]  body_len;
  logic [7:0]        command_id;
  logic [TICK_W-1:0] window;
  logic [TICK_W-1:0] elapsed;
  logic              retry_done;
  logic [7:0]        last_rx;
  logic              header_seen;

  result_t run_q[$];
  result_t expected_q[$];
  result_t want;
  result_t item;

  function automatic void queue_result(logic kind, logic [7:0] tx, status_t st);
    result_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.status     = st;
    r.end_of_run = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void start_attempt();
    elapsed     = '0;
    header_seen = 1'b0;
    last_rx     = 8'h00;
    cmd_phase   = PH_WAIT;
  endfunction

  function automatic void emit_frame();
    logic [15:0] frame_len;
    logic [7:0]  sum;
    frame_len = 16'(body_len) + 16'd1;
    sum       = command_id;
    queue_result(KIND_TX, HDR0_BYTE, ST_ACK);
    queue_result(KIND_TX, HDR1_BYTE, ST_ACK);
    queue_result(KIND_TX, frame_len[15:8], ST_ACK);
    queue_result(KIND_TX, frame_len[7:0], ST_ACK);
    queue_result(KIND_TX, command_id, ST_ACK);
    for (int i = 0; i < int'(body_len); i++) begin
      queue_result(KIND_TX, body_mem[i], ST_ACK);
      sum = sum ^ body_mem[i];
    end
    queue_result(KIND_TX, sum, ST_ACK);
    queue_result(KIND_TX, TRL0_BYTE, ST_ACK);
    queue_result(KIND_TX, TRL1_BYTE, ST_ACK);
    start_attempt();
  endfunction

  // first failure re-sends the frame; anything else is final
  function automatic void close_attempt(status_t st);
    if (st != ST_ACK && !retry_done) begin
      retry_done = 1'b1;
      emit_frame();
    end else begin
      queue_result(KIND_STATUS, 8'h00, st);
      cmd_phase   = PH_IDLE;
      body_len    = '0;
      retry_done  = 1'b0;
      header_seen = 1'b0;
      last_rx     = 8'h00;
      elapsed     = '0;
    end
  endfunction

  function automatic void apply_request(logic [1:0] mode, logic [7:0] id, logic [7:0] data,
                                        logic last, logic [15:0] tmo);
    case (mode)
      MODE_BODY: begin
        if (cmd_phase != PH_WAIT) begin
          if (cmd_phase == PH_IDLE) begin
            command_id = id;
            window     = tmo[15:1];
            body_len   = '0;
            retry_done = 1'b0;
            cmd_phase  = PH_COLLECT;
          end
          // drop bytes past the store
          if (int'(body_len) < MAX_BODY) begin
            body_mem[body_len[IDX_W-1:0]] = data;
            body_len = body_len + 1'b1;
          end
          if (last) emit_frame();
        end
      end
      MODE_RX: begin
        if (cmd_phase == PH_WAIT) begin
          if (last_rx == HDR0_BYTE && data == HDR1_BYTE && !header_seen) header_seen = 1'b1;
          if (header_seen && last_rx == ACK_BYTE) begin
            close_attempt(data == command_id ? ST_ACK : ST_UNKNOWN);
          end else if (header_seen && last_rx == NACK_BYTE) begin
            close_attempt(data == command_id ? ST_NACK : ST_UNKNOWN);
          end else begin
            last_rx = data;
          end
        end
      end
      MODE_TICK: begin
        if (cmd_phase == PH_WAIT) begin
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (elapsed >= window) close_attempt(ST_TIMEOUT);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    if (expected_q.size() == 0) begin
      $error("unexpected result: kind %0d tx_byte %02h status %0d end_of_run %0d",
             out_mon.kind, out_mon.tx_byte, out_mon.status, out_mon.end_of_run);
      mismatch_count++;
      return;
    end
    want = expected_q.pop_front();
    if (out_mon.kind !== want.kind) begin
      $error("kind mismatch: expected %0d, actual %0d", want.kind, out_mon.kind);
      mismatch_count++;
    end
    if (out_mon.tx_byte !== want.tx_byte) begin
      $error("tx_byte mismatch: expected %02h, actual %02h", want.tx_byte, out_mon.tx_byte);
      mismatch_count++;
    end
    if (out_mon.status !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, out_mon.status);
      mismatch_count++;
    end
    if (out_mon.end_of_run !== want.end_of_run) begin
      $error("end_of_run mismatch: expected %0d, actual %0d",
             want.end_of_run, out_mon.end_of_run);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      body_len        = '0;
      command_id      = 8'h00;
      window          = '0;
      elapsed         = '0;
      retry_done      = 1'b0;
      cmd_phase       = PH_IDLE;
      last_rx         = 8'h00;
      header_seen     = 1'b0;
      mismatch_count  = 0;
      pending_results = 0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) begin
        run_q.delete();
        apply_request(in_mon.mode, in_mon.message_id, in_mon.data_byte,
                      in_mon.body_end, in_mon.timeout_ms);
        for (int i = 0; i < run_q.size(); i++) begin
          item = run_q[i];
          // flag the last result of this request
          if (i == run_q.size() - 1) item.end_of_run = 1'b1;
          expected_q.push_back(item);
        end
      end
      pending_results = expected_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives body bytes, reply bytes and ticks into the command framer under
// four flow-control phases; a side monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cfam_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_REQUESTS = 105;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int acted_requests = 0;
  int requests_taken = 0;
  int results_taken = 0;
  int statuses_seen = 0;
  int quiet_cycles = 0;
  logic [7:0] last_cmd_id = 8'h00;

  int     mismatch_count;
  int     pending_results;
  phase_t cmd_phase;

  cfam_in_if  in_ch();
  cfam_out_if out_ch();

  command_framer_ack_matcher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cfam_frame_monitor monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .cmd_phase       (cmd_phase)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // count traffic and end a hung run
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) requests_taken++;
      if (out_ch.valid && out_ch.ready) begin
        results_taken++;
        if (out_ch.kind == KIND_STATUS) statuses_seen++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("command_framer_ack_matcher_unit test failed");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [1:0] mode, input logic [7:0] id,
                              input logic [7:0] data, input logic last,
                              input logic [15:0] tmo);
    if ((mode == MODE_BODY && cmd_phase != PH_WAIT) ||
        ((mode == MODE_RX || mode == MODE_TICK) && cmd_phase == PH_WAIT)) begin
      acted_requests++;
    end
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.message_id <= id;
    in_ch.data_byte  <= data;
    in_ch.body_end   <= last;
    in_ch.timeout_ms <= tmo;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_ignored();
    case ($urandom_range(2))
      0: send_request(MODE_TICK, 8'($urandom), 8'($urandom), 1'($urandom),
                      16'($urandom));
      1: send_request(MODE_RX, 8'($urandom), 8'($urandom), 1'($urandom),
                      16'($urandom));
      default: send_request(MODE_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom),
                            16'($urandom));
    endcase
  endtask

  task automatic send_command();
    int          body_bytes;
    int          pick;
    logic [15:0] tmo;
    logic [7:0]  id;
    pick = $urandom_range(99);
    if (pick < 80) body_bytes = $urandom_range(1, 4);
    else if (pick < 95) body_bytes = $urandom_range(5, MAX_BODY);
    else body_bytes = $urandom_range(MAX_BODY + 1, MAX_BODY + 4);
    pick = $urandom_range(99);
    if (pick < 50) tmo = 16'($urandom_range(0, 12));
    else if (pick < 80) tmo = 16'($urandom_range(13, 200));
    else tmo = 16'($urandom_range(0, 65535));
    id = 8'($urandom);
    if ($urandom_range(99) < 10) send_ignored();
    last_cmd_id = id;
    for (int i = 0; i < body_bytes; i++) begin
      // stray traffic during collection is dropped
      if (i > 0 && $urandom_range(99) < 8) send_ignored();
      send_request(MODE_BODY, (i == 0) ? id : 8'($urandom), 8'($urandom),
                   i == body_bytes - 1, (i == 0) ? tmo : 16'($urandom));
    end
  endtask

  task automatic send_reply_traffic();
    logic [7:0] reply[$];
    logic [7:0] noise;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      reply = {HDR0_BYTE, HDR1_BYTE, ($urandom_range(1) != 0) ? ACK_BYTE : NACK_BYTE,
               ($urandom_range(99) < 70) ? last_cmd_id : 8'($urandom)};
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(2))
          0: reply[$urandom_range(3)] = 8'($urandom);
          1: reply.delete($urandom_range(3));
          default: reply.insert($urandom_range(3), 8'($urandom));
        endcase
      end
      foreach (reply[i]) send_request(MODE_RX, 8'($urandom), reply[i], 1'($urandom),
                                      16'($urandom));
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 4)) send_request(MODE_TICK, 8'($urandom), 8'($urandom),
                                                 1'($urandom), 16'($urandom));
    end else if (pick < 90) begin
      case ($urandom_range(4))
        0: noise = HDR0_BYTE;
        1: noise = HDR1_BYTE;
        2: noise = ACK_BYTE;
        3: noise = NACK_BYTE;
        default: noise = 8'($urandom);
      endcase
      send_request(MODE_RX, 8'($urandom), noise, 1'($urandom), 16'($urandom));
    end else if (pick < 95) begin
      send_request(MODE_BODY, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
    end else begin
      send_request(MODE_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall);
    int start_count;
    idle_pct    = sender_idle;
    stall_pct   = receiver_stall;
    start_count = acted_requests;
    while (acted_requests - start_count < PHASE_REQUESTS) begin
      if (cmd_phase == PH_WAIT) send_reply_traffic();
      else send_command();
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_BODY;
    in_ch.message_id = 8'h00;
    in_ch.data_byte  = 8'h00;
    in_ch.body_end   = 1'b0;
    in_ch.timeout_ms = 16'h0000;
    out_ch.ready     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stray traffic while idle
    send_request(MODE_TICK, 8'h00, 8'h00, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, HDR0_BYTE, 1'b0, 16'h0000);
    send_request(MODE_UNUSED, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);

    // one-byte command at the field maxima, acked on the first attempt
    send_request(MODE_BODY, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
    send_request(MODE_RX, 8'h00, HDR0_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, HDR1_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, ACK_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, 8'hFF, 1'b0, 16'h0000);

    // zero window: byte before the tick still counts, retry, then timeout
    send_request(MODE_BODY, 8'h00, 8'h00, 1'b0, 16'h0000);
    send_request(MODE_BODY, 8'hAA, 8'h5A, 1'b1, 16'hFFFF);
    send_request(MODE_RX, 8'h00, HDR0_BYTE, 1'b0, 16'h0000);
    send_request(MODE_TICK, 8'h00, 8'h00, 1'b0, 16'h0000);
    send_request(MODE_BODY, 8'h11, 8'h22, 1'b1, 16'h0010);
    send_request(MODE_TICK, 8'h00, 8'h00, 1'b0, 16'h0000);

    // nack on the first attempt, wrong id on the retry
    send_request(MODE_BODY, 8'h3C, 8'h81, 1'b1, 16'd6);
    send_request(MODE_RX, 8'h00, HDR0_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, HDR1_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, NACK_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, 8'h3C, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, HDR0_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, HDR1_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, ACK_BYTE, 1'b0, 16'h0000);
    send_request(MODE_RX, 8'h00, 8'h55, 1'b0, 16'h0000);

    run_phase(0, 0);
    run_phase(78, 0);
    run_phase(0, 78);
    run_phase(28, 28);
    in_ch.valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests (%0d acted on) and %0d results, %0d of them final statuses,",
             requests_taken, acted_requests, results_taken, statuses_seen);
    $display("across free-running, sender-idle, receiver-stall and mixed flow control.");
    if (mismatch_count == 0) begin
      $display("command_framer_ack_matcher_unit test passed");
    end else begin
      $display("command_framer_ack_matcher_unit test failed");
    end
    $finish;
  end

endmodule
